// ===== hdl/sliding_window_transport_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window transport engine: assertion macros
// Shared assertion forms for the engine's RTL checks.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_TRANSPORT_ENGINE_DEFINES_SVH
`define SLIDING_WINDOW_TRANSPORT_ENGINE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define SWTE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swte assertion failed");

// Consequent holds in the cycle after the antecedent.
`define SWTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swte assertion failed");

`endif

// ===== hdl/swte_pkg.sv =====
// ----------------------------------------------------------------------------
// swte_pkg
// Shared constants, codes and types of the sliding window transport engine.
// ----------------------------------------------------------------------------
package swte_pkg;

   localparam int RECEIVE_DEPTH_DEF = 32;

   localparam int SEQ_W       = 32;
   localparam int REQ_DATA_W  = 72;   // 65 field bits padded to whole bytes
   localparam int RSP_DATA_W  = 64;
   localparam int OP_W        = 2;
   localparam int KIND_W      = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int TIMER_W     = 16;
   localparam int WINDOW_W    = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = 1'd1;

   // request kinds
   localparam logic [OP_W-1:0] OP_HEADER = 2'd0;
   localparam logic [OP_W-1:0] OP_LOCAL  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_DELIVER    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACK        = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEND       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd4;

   localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = 16'd1000;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 8'd20;
   localparam logic [SEQ_W-1:0]    SEQ_RESET     = 32'd1;

   typedef struct packed {
      logic [SEQ_W-1:0] a;
      logic [SEQ_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [SEQ_W-1:0] diff;   // a - b, modulo 2^32
      logic             ge;     // a >= b, unsigned
      logic             eq;     // a == b
   } alu_rsp_type;

endpackage

// ===== hdl/swte_ram.sv =====
// ----------------------------------------------------------------------------
// swte_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swte_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/swte_alu.sv =====
// ----------------------------------------------------------------------------
// swte_alu
// Shared 32-bit subtract and compare unit used by the ack, packet, window and tick steps.
// ----------------------------------------------------------------------------
module swte_alu (
   input  swte_pkg::alu_req_type req,
   output swte_pkg::alu_rsp_type rsp
);
   import swte_pkg::*;

   logic [SEQ_W:0] wide_diff;

   assign wide_diff = {1'b0, req.a} - {1'b0, req.b};

   always_comb begin
      rsp.diff = wide_diff[SEQ_W-1:0];
      rsp.ge   = ~wide_diff[SEQ_W];
      rsp.eq   = (wide_diff[SEQ_W-1:0] == '0);
   end

endmodule

// ===== hdl/sliding_window_transport_engine.sv =====
// Flow: one transaction in work at a time. A header with data takes the ack, packet, read and
// check steps, a read and check again per in-order packet delivered, then the window step; a
// header without data the ack step, a local segment the window step, a tick the tick step;
// an unused op ends in idle. A stalled result in the output register holds the sequencer.
// A final header or local result is registered in the window step, a retransmit in the tick
// step. Reset is synchronous; a clearing pass then zeroes the presence RAM.
// ----------------------------------------------------------------------------
// sliding_window_transport_engine
// Header-level selective repeat engine with cumulative ack and retransmit timer.
// ----------------------------------------------------------------------------
`include "sliding_window_transport_engine_defines.svh"

module sliding_window_transport_engine #(
   parameter int RECEIVE_DEPTH = swte_pkg::RECEIVE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               csr_wr_en,
   input  logic [swte_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [swte_pkg::CSR_DATA_W-1:0]    csr_wdata,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pkt_num [31:0], ack_number [63:32], data_waiting [64], zero pad
   input  logic [swte_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op [1:0]
   input  logic [swte_pkg::OP_W-1:0]          req_tuser,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sequence_res [31:0], ack_value [63:32]
   output logic [swte_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // kind [2:0]
   output logic [swte_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast
);
   import swte_pkg::*;

   localparam int SLOT_W = $clog2(RECEIVE_DEPTH);
   localparam logic [SLOT_W:0]   DEPTH_EXT  = (SLOT_W + 1)'(RECEIVE_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(RECEIVE_DEPTH - 1);
   localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1);
   localparam logic [SEQ_W-1:0]  DEPTH_WORD = SEQ_W'(RECEIVE_DEPTH);

   typedef enum logic [7:0] {
      S_CLR  = 8'b0000_0001,
      S_IDLE = 8'b0000_0010,
      S_ACK  = 8'b0000_0100,
      S_PKT  = 8'b0000_1000,
      S_RD   = 8'b0001_0000,
      S_CHK  = 8'b0010_0000,
      S_WIN  = 8'b0100_0000,
      S_TICK = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SEQ_W-1:0]     pkt_ff, pkt_in;
   logic [SEQ_W-1:0]     ack_ff, ack_in;
   logic                 wait_ff, wait_in;
   logic [TIMER_W-1:0]   timeout_ff, timeout_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;
   logic [SEQ_W-1:0]     send_base_ff, send_base_in;
   logic [SEQ_W-1:0]     next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0]     rcv_base_ff, rcv_base_in;
   logic [SLOT_W-1:0]    rb_slot_ff, rb_slot_in;
   logic                 timer_run_ff, timer_run_in;
   logic [TIMER_W-1:0]   timer_cnt_ff, timer_cnt_in;
   logic                 peer_seen_ff, peer_seen_in;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]    out_kind_ff, out_kind_in;
   logic [SEQ_W-1:0]     out_seq_ff, out_seq_in;
   logic [SEQ_W-1:0]     out_ack_ff, out_ack_in;
   logic                 out_last_ff, out_last_in;

   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;

   logic                 ram_we;
   logic [SLOT_W-1:0]    ram_waddr;
   logic                 ram_wdata;
   logic                 ram_rdata;

   logic                 out_free;
   logic                 emit_go;
   logic                 send_go;
   logic [SEQ_W-1:0]     ack_inc;
   logic [SEQ_W-1:0]     rb_dec;
   logic                 win_ok;
   logic                 in_store;
   logic [SLOT_W:0]      slot_sum;
   logic [SLOT_W-1:0]    pkt_slot;
   logic [TIMER_W:0]     cnt_inc;
   logic [TIMER_W-1:0]   cnt_sat;

   swte_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   swte_ram #(
      .WIDTH (1),
      .DEPTH (RECEIVE_DEPTH)
   ) u_present (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rb_slot_ff),
      .rd_data (ram_rdata)
   );

   // shared unit operand select
   always_comb begin
      unique case (state_ff)
         S_ACK: begin
            alu_req.a = ack_ff;
            alu_req.b = send_base_ff;
         end
         S_PKT: begin
            alu_req.a = pkt_ff;
            alu_req.b = rcv_base_ff;
         end
         S_WIN: begin
            alu_req.a = next_seq_ff;
            alu_req.b = send_base_ff;
         end
         S_TICK: begin
            alu_req.a = send_base_ff;
            alu_req.b = next_seq_ff;
         end
         default: begin
            alu_req.a = '0;
            alu_req.b = '0;
         end
      endcase
   end

   assign ack_inc  = ack_ff + SEQ_W'(1);
   assign rb_dec   = rcv_base_ff - SEQ_W'(1);
   assign win_ok   = alu_rsp.ge && (alu_rsp.diff[SEQ_W-1:WINDOW_W] == '0) &&
                     (alu_rsp.diff[WINDOW_W-1:0] <= window_ff);
   assign in_store = (alu_rsp.diff < DEPTH_WORD);
   assign slot_sum = {1'b0, rb_slot_ff} + {1'b0, alu_rsp.diff[SLOT_W-1:0]};
   assign pkt_slot = (slot_sum >= DEPTH_EXT) ? SLOT_W'(slot_sum - DEPTH_EXT)
                                             : slot_sum[SLOT_W-1:0];
   assign cnt_inc  = {1'b0, timer_cnt_ff} + (TIMER_W + 1)'(1);
   assign cnt_sat  = cnt_inc[TIMER_W] ? '1 : cnt_inc[TIMER_W-1:0];
   assign out_free = ~out_valid_ff | rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pkt_in       = pkt_ff;
      ack_in       = ack_ff;
      wait_in      = wait_ff;
      timeout_in   = timeout_ff;
      window_in    = window_ff;
      send_base_in = send_base_ff;
      next_seq_in  = next_seq_ff;
      rcv_base_in  = rcv_base_ff;
      rb_slot_in   = rb_slot_ff;
      timer_run_in = timer_run_ff;
      timer_cnt_in = timer_cnt_ff;
      peer_seen_in = peer_seen_ff;
      clr_in       = clr_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_kind_in  = out_kind_ff;
      out_seq_in   = out_seq_ff;
      out_ack_in   = out_ack_ff;
      out_last_in  = out_last_ff;
      emit_go      = 1'b0;
      send_go      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = rb_slot_ff;
      ram_wdata    = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_wdata;
            CSR_WINDOW:  window_in  = csr_wdata[WINDOW_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               pkt_in  = req_tdata[SEQ_W-1:0];
               ack_in  = req_tdata[2*SEQ_W-1:SEQ_W];
               wait_in = req_tdata[2*SEQ_W];
               unique case (req_tuser)
                  OP_HEADER: state_in = S_ACK;
                  OP_LOCAL:  state_in = S_WIN;
                  OP_TICK:   state_in = S_TICK;
                  OP_UNUSED: state_in = S_IDLE;
               endcase
            end
         end
         S_ACK: begin
            peer_seen_in = 1'b1;
            if (alu_rsp.ge && (ack_ff != '0)) begin
               send_base_in = ack_inc;
               if (ack_inc == next_seq_ff) begin
                  timer_run_in = 1'b0;
               end else begin
                  timer_cnt_in = '0;
               end
            end
            state_in = (pkt_ff == '0) ? S_IDLE : S_PKT;
         end
         S_PKT: begin
            if (alu_rsp.ge && in_store) begin
               ram_we    = 1'b1;
               ram_waddr = pkt_slot;
               ram_wdata = 1'b1;
               state_in  = S_RD;
            end else if (alu_rsp.ge) begin
               // beyond the store: flag dropped, hold until the output frees
               if (out_free) begin
                  emit_go     = 1'b1;
                  out_kind_in = KIND_DROPPED;
                  out_seq_in  = pkt_ff;
                  out_ack_in  = '0;
                  out_last_in = 1'b0;
                  state_in    = S_RD;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (ram_rdata) begin
               if (out_free) begin
                  emit_go     = 1'b1;
                  out_kind_in = KIND_DELIVER;
                  out_seq_in  = rcv_base_ff;
                  out_ack_in  = '0;
                  out_last_in = 1'b0;
                  ram_we      = 1'b1;
                  rcv_base_in = rcv_base_ff + SEQ_W'(1);
                  rb_slot_in  = (rb_slot_ff == SLOT_LAST) ? '0 : rb_slot_ff + SLOT_W'(1);
                  state_in    = S_RD;
               end
            end else begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            if (op_ff == OP_HEADER) begin
               if (out_free) begin
                  emit_go     = 1'b1;
                  out_last_in = 1'b1;
                  out_ack_in  = rb_dec;
                  if (wait_ff && win_ok) begin
                     send_go     = 1'b1;
                     out_kind_in = KIND_SEND;
                     out_seq_in  = next_seq_ff;
                  end else begin
                     out_kind_in = KIND_ACK;
                     out_seq_in  = '0;
                  end
                  state_in = S_IDLE;
               end
            end else if (peer_seen_ff && win_ok) begin
               if (out_free) begin
                  emit_go     = 1'b1;
                  send_go     = 1'b1;
                  out_kind_in = KIND_SEND;
                  out_seq_in  = next_seq_ff;
                  out_ack_in  = '0;
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (!timer_run_ff) begin
               state_in = S_IDLE;
            end else if (cnt_sat < timeout_ff) begin
               timer_cnt_in = cnt_sat;
               state_in     = S_IDLE;
            end else if (alu_rsp.eq) begin
               timer_cnt_in = '0;
               state_in     = S_IDLE;
            end else if (out_free) begin
               emit_go      = 1'b1;
               out_kind_in  = KIND_RETRANSMIT;
               out_seq_in   = send_base_ff;
               out_ack_in   = '0;
               out_last_in  = 1'b1;
               timer_cnt_in = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (send_go) begin
         next_seq_in = next_seq_ff + SEQ_W'(1);
         if (!timer_run_ff) begin
            timer_run_in = 1'b1;
            timer_cnt_in = '0;
         end
      end

      if (emit_go) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         timeout_ff   <= TIMEOUT_RESET;
         window_ff    <= WINDOW_RESET;
         send_base_ff <= SEQ_RESET;
         next_seq_ff  <= SEQ_RESET;
         rcv_base_ff  <= SEQ_RESET;
         rb_slot_ff   <= SLOT_RESET;
         timer_run_ff <= 1'b0;
         timer_cnt_ff <= '0;
         peer_seen_ff <= 1'b0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         window_ff    <= window_in;
         send_base_ff <= send_base_in;
         next_seq_ff  <= next_seq_in;
         rcv_base_ff  <= rcv_base_in;
         rb_slot_ff   <= rb_slot_in;
         timer_run_ff <= timer_run_in;
         timer_cnt_ff <= timer_cnt_in;
         peer_seen_ff <= peer_seen_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pkt_ff      <= pkt_in;
      ack_ff      <= ack_in;
      wait_ff     <= wait_in;
      out_kind_ff <= out_kind_in;
      out_seq_ff  <= out_seq_in;
      out_ack_ff  <= out_ack_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ack_ff, out_seq_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   `SWTE_ASSERT_NEXT(a_one_item_at_a_time, clock, reset,
      req_tvalid && req_tready && (req_tuser != OP_UNUSED), !req_tready)
   `SWTE_ASSERT_SAME(a_no_result_overwrite, clock, reset, emit_go, out_free)
   `SWTE_ASSERT_NEXT(a_send_starts_timer, clock, reset, send_go, timer_run_ff)
   `SWTE_ASSERT_NEXT(a_deliver_advances_base, clock, reset,
      state_ff == S_CHK && ram_rdata && out_free,
      rcv_base_ff == $past(rcv_base_ff) + SEQ_W'(1))

endmodule

// ===== verif/sliding_window_transport_engine_checker.sv =====
// ----------------------------------------------------------------------------
// sliding_window_transport_engine_checker
// Watches the request, response and register ports of the transport engine.
// Keeps its own copy of window, receive map and timer state, works out the
// results of every accepted request and compares each accepted response,
// field by field, with the oldest result still awaited.
// ----------------------------------------------------------------------------
module sliding_window_transport_engine_checker #(
   parameter int RECEIVE_DEPTH = swte_pkg::RECEIVE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [swte_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [swte_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [swte_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [swte_pkg::OP_W-1:0]         req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [swte_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [swte_pkg::KIND_W-1:0]       rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                fail_count,
   output int                                pending,
   output int                                results_checked,
   output int                                delivered_count,
   output int                                dropped_count,
   output int                                retransmit_count,
   // window state, for shaping the stimulus
   output logic [swte_pkg::SEQ_W-1:0]        acked_base,
   output logic [swte_pkg::SEQ_W-1:0]        sent_next,
   output logic [swte_pkg::SEQ_W-1:0]        deliver_base
);
   timeunit 1ns;
   timeprecision 1ps;
   import swte_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      logic [SEQ_W-1:0]  ack;
      logic              last;
   } segment_event_type;

   localparam logic [SEQ_W:0] DEPTH_WIDE = (SEQ_W + 1)'(RECEIVE_DEPTH);

   segment_event_type awaited_events[$];
   segment_event_type item_events[$];

   logic [TIMER_W-1:0]  timeout_ticks;
   logic [WINDOW_W-1:0] send_window;
   logic [SEQ_W-1:0]    send_base;
   logic [SEQ_W-1:0]    next_seq;
   logic [SEQ_W-1:0]    recv_base;
   logic                present [RECEIVE_DEPTH];
   logic                timer_on;
   logic [TIMER_W-1:0]  timer_cnt;
   logic                peer_seen;

   assign acked_base   = send_base;
   assign sent_next    = next_seq;
   assign deliver_base = recv_base;

   initial begin
      fail_count       = 0;
      pending          = 0;
      results_checked  = 0;
      delivered_count  = 0;
      dropped_count    = 0;
      retransmit_count = 0;
   end

   function automatic int unsigned slot_of(logic [SEQ_W-1:0] seq);
      return seq % RECEIVE_DEPTH;
   endfunction

   function automatic logic window_open();
      logic [SEQ_W:0] right_edge;
      right_edge = {1'b0, send_base} + send_window;
      return (next_seq >= send_base) && ({1'b0, next_seq} <= right_edge);
   endfunction

   function automatic void add_result(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                                      logic [SEQ_W-1:0] ack);
      segment_event_type ev;
      ev.kind = kind;
      ev.seq  = seq;
      ev.ack  = ack;
      ev.last = 1'b0;
      item_events.push_back(ev);
   endfunction

   function automatic void launch_segment(logic [SEQ_W-1:0] ack);
      add_result(KIND_SEND, next_seq, ack);
      next_seq = next_seq + 1;
      if (!timer_on) begin
         timer_on  = 1'b1;
         timer_cnt = '0;
      end
   endfunction

   function automatic void reset_transport();
      timeout_ticks = TIMEOUT_RESET;
      send_window   = WINDOW_RESET;
      send_base     = SEQ_RESET;
      next_seq      = SEQ_RESET;
      recv_base     = SEQ_RESET;
      timer_on      = 1'b0;
      timer_cnt     = '0;
      peer_seen     = 1'b0;
      foreach (present[i]) present[i] = 1'b0;
   endfunction

   // Work out every result one request causes and queue them in order.
   function automatic void advance_transport(logic [OP_W-1:0] op, logic [SEQ_W-1:0] pkt,
                                             logic [SEQ_W-1:0] ackn, logic waiting);
      item_events.delete();
      case (op)
         OP_HEADER: begin
            peer_seen = 1'b1;
            if ((ackn != 0 || send_base == SEQ_RESET) && ackn >= send_base) begin
               send_base = ackn + 1;
               if (send_base == next_seq) timer_on = 1'b0;
               else timer_cnt = '0;
            end
            if (pkt != 0) begin
               if (pkt >= recv_base) begin
                  if ({1'b0, pkt} < {1'b0, recv_base} + DEPTH_WIDE)
                     present[slot_of(pkt)] = 1'b1;
                  else
                     add_result(KIND_DROPPED, pkt, '0);
               end
               // deliver the in-order run now complete
               while (present[slot_of(recv_base)]) begin
                  present[slot_of(recv_base)] = 1'b0;
                  add_result(KIND_DELIVER, recv_base, '0);
                  recv_base = recv_base + 1;
               end
               if (waiting && window_open()) launch_segment(recv_base - 1);
               else add_result(KIND_ACK, '0, recv_base - 1);
            end
         end
         OP_LOCAL: begin
            if (peer_seen && window_open()) launch_segment('0);
         end
         OP_TICK: begin
            if (timer_on) begin
               if (timer_cnt != '1) timer_cnt = timer_cnt + 1'b1;
               if (timer_cnt >= timeout_ticks) begin
                  timer_cnt = '0;
                  if (send_base != next_seq) add_result(KIND_RETRANSMIT, send_base, '0);
               end
            end
         end
         default: ;
      endcase
      if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
      foreach (item_events[i]) awaited_events.push_back(item_events[i]);
   endfunction

   function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                       logic [SEQ_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      segment_event_type want;
      if (reset) begin
         reset_transport();
         awaited_events.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_ticks = csr_wdata;
               CSR_WINDOW:  send_window   = csr_wdata[WINDOW_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_events.size() == 0) begin
               fail_count++;
               $display({"%0t: response with nothing awaited, expected none, ",
                         "actual kind %0d seq %0h ack %0h last %0b"},
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tlast);
            end else begin
               want = awaited_events.pop_front();
               check_field("kind", SEQ_W'(want.kind), SEQ_W'(rsp_tuser));
               check_field("sequence", want.seq, rsp_tdata[31:0]);
               check_field("ack value", want.ack, rsp_tdata[63:32]);
               check_field("last", SEQ_W'(want.last), SEQ_W'(rsp_tlast));
               results_checked++;
               case (want.kind)
                  KIND_DELIVER:    delivered_count++;
                  KIND_DROPPED:    dropped_count++;
                  KIND_RETRANSMIT: retransmit_count++;
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready)
            advance_transport(req_tuser, req_tdata[31:0], req_tdata[63:32], req_tdata[64]);
      end
      pending = awaited_events.size();
   end

endmodule

// ===== verif/sliding_window_transport_engine_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_transport_engine_tb
// Drives header, local-segment and timer-tick requests into the engine under
// several window and timeout settings: a directed opening over the corner
// cases, then mostly well-formed peer traffic with random content and some
// stale, wrapped and out-of-range noise. Both sides idle at random, and the
// receiver holds off once long enough to back the engine up. Checking lives
// in the checker module; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module sliding_window_transport_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swte_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6 + 2 * RECEIVE_DEPTH_DEF + 8;
   localparam int STALL_LIMIT   = 4000;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;

   int                     fail_count;
   int                     pending;
   int                     results_checked;
   int                     delivered_count;
   int                     dropped_count;
   int                     retransmit_count;
   logic [SEQ_W-1:0]       acked_base;
   logic [SEQ_W-1:0]       sent_next;
   logic [SEQ_W-1:0]       deliver_base;

   int                     idle_pct;
   int                     items_sent;
   int                     quiet_cycles;
   int                     hold_left;
   logic                   rsp_hold_req;

   sliding_window_transport_engine dut (.*);

   sliding_window_transport_engine_checker transport_checker (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results still awaited",
                  STALL_LIMIT, pending);
         $display("** sliding_window_transport_engine: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Call at a falling edge; returns at the edge that accepts the transaction.
   task automatic drive_transaction(logic [OP_W-1:0] op, logic [SEQ_W-1:0] pkt,
                                    logic [SEQ_W-1:0] ackn, logic waiting);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, waiting, ackn, pkt};
      do @(posedge clock); while (!req_tready);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic offer(logic [OP_W-1:0] op, logic [SEQ_W-1:0] pkt, logic [SEQ_W-1:0] ackn,
                        logic waiting);
      @(negedge clock);
      drive_transaction(op, pkt, ackn, waiting);
   endtask

   task automatic program_regs(logic [TIMER_W-1:0] timeout, logic [WINDOW_W-1:0] window);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= timeout;
      @(negedge clock);
      csr_index <= CSR_WINDOW;
      csr_wdata <= {8'd0, window};
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drain all awaited results, then cover a request still in work with no result.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic offer_random(int count, bit wild_acks);
      int               done;
      int               r;
      logic [OP_W-1:0]  op;
      logic [SEQ_W-1:0] pkt;
      logic [SEQ_W-1:0] ackn;
      logic [SEQ_W-1:0] span;
      logic             waiting;
      done = 0;
      while (done < count) begin
         @(negedge clock);
         r       = $urandom_range(0, 99);
         waiting = 1'($urandom_range(0, 1));
         pkt     = $urandom;
         ackn    = $urandom;
         if (r < 50) op = OP_HEADER;
         else if (r < 72) op = OP_LOCAL;
         else if (r < 95) op = OP_TICK;
         else op = OP_UNUSED;
         if (op == OP_HEADER) begin
            r = $urandom_range(0, 99);
            if (r < 10) pkt = '0;
            else if (r < 15) pkt = deliver_base - $urandom_range(1, 5);
            else if (r < 22) pkt = deliver_base + $urandom_range(RECEIVE_DEPTH_DEF,
                                                                 RECEIVE_DEPTH_DEF + 8);
            else if (r < 25) pkt = $urandom;
            else if (r < 55) pkt = deliver_base;
            else pkt = deliver_base + $urandom_range(1, RECEIVE_DEPTH_DEF - 1);
            // acknowledge only what has been sent, apart from a little noise
            span = sent_next - acked_base;
            if (span > 300) span = '0;
            r = $urandom_range(0, 99);
            if (wild_acks) ackn = $urandom;
            else if (r < 10) ackn = '0;
            else if (r < 15 && acked_base > 3) ackn = acked_base - $urandom_range(1, 3);
            else ackn = acked_base - 1 + $urandom_range(0, span);
         end
         drive_transaction(op, pkt, ackn, waiting);
         if (op != OP_UNUSED) done++;
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_hold_req = 1'b0;
      idle_pct     = 33;
      items_sent   = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // let the presence map clearing pass finish
      repeat (RECEIVE_DEPTH_DEF + 8) @(negedge clock);

      // directed opening: small window, quick timeout
      program_regs(16'd2, 8'd4);
      offer(OP_LOCAL, 32'd0, 32'd0, 1'b1);           // no peer yet: nothing sent
      offer(OP_TICK, 32'd0, 32'd0, 1'b0);            // timer stopped
      offer(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      offer(OP_HEADER, 32'd0, 32'd0, 1'b1);          // ack-only header at base one
      repeat (6) offer(OP_LOCAL, 32'd0, 32'd0, 1'b0); // fill the window, then one over
      offer(OP_TICK, 32'd0, 32'd0, 1'b0);
      offer(OP_TICK, 32'd0, 32'd0, 1'b0);            // timeout: resend the base
      offer(OP_HEADER, 32'd3, 32'd2, 1'b1);          // out of order, piggyback
      offer(OP_HEADER, 32'd1, 32'd0, 1'b0);
      offer(OP_HEADER, 32'd2, 32'd6, 1'b0);          // all acked: timer stops
      offer(OP_HEADER, 32'd2, 32'd5, 1'b0);          // old data, stale ack
      offer(OP_HEADER, 32'd35, 32'd0, 1'b0);         // last slot of the store
      offer(OP_HEADER, 32'd36, 32'd0, 1'b0);         // one past the store
      offer(OP_HEADER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // ack wraps the base
      offer(OP_HEADER, 32'd0, 32'd6, 1'b0);
      offer(OP_LOCAL, 32'd0, 32'd0, 1'b0);
      offer(OP_TICK, 32'd0, 32'd0, 1'b0);
      offer(OP_TICK, 32'd0, 32'd0, 1'b0);
      offer(OP_HEADER, 32'd4, 32'd7, 1'b1);
      offer(OP_HEADER, 32'd5, 32'd0, 1'b0);
      settle();

      program_regs(16'd1, 8'd1);
      offer_random(50, 1'b0);
      settle();

      program_regs(16'd65535, 8'd255);
      offer_random(50, 1'b0);
      settle();

      // back the engine up behind a long receiver hold-off
      program_regs(16'd5, 8'd20);
      @(posedge clock);
      rsp_hold_req = 1'b1;
      offer_random(60, 1'b0);
      settle();

      program_regs(16'd3, 8'd8);
      idle_pct = 0;
      offer_random(30, 1'b0);
      idle_pct = 33;
      offer_random(22, 1'b0);
      offer_random(8, 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d requests over five window/timeout settings, idle and stalled sides,",
               items_sent);
      $display("a %0d-cycle receiver hold-off; %0d results: %0d delivered, %0d dropped,",
               HOLD_CYCLES, results_checked, delivered_count, dropped_count);
      $display("%0d resent.", retransmit_count);
      if (fail_count == 0) begin
         $display("** sliding_window_transport_engine: PASSED **");
      end else begin
         $display("** sliding_window_transport_engine: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/swte_pkg.sv
hdl/swte_ram.sv
hdl/swte_alu.sv
hdl/sliding_window_transport_engine.sv
verif/sliding_window_transport_engine_checker.sv
verif/sliding_window_transport_engine_tb.sv
